// ----- design/tpgm_pkg.sv -----
// Shared constants, command and status types for the two-path grid collector.
package tpgm_pkg;

  localparam int MAX_N_DEFAULT = 16;
  localparam int VALUE_W       = 10;
  localparam int SUM_W         = 16;
  localparam int SIZE_W        = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
  localparam logic [SUM_W-1:0]  SUM_LIMIT  = {SUM_W{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // write one accepted cell word
    logic init_rd;  // read the corner cell
    logic init_wr;  // seed the first layer and start the diagonal loop
    logic rd0;      // read gains and the first predecessor pair
    logic rd1;      // read the second predecessor pair
    logic wr;       // write one DP entry and advance the indices
    logic publish;  // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic grid_last;  // current load position is the last cell
    logic n_one;      // grid side is one
    logic loop_end;   // current DP entry is the final one
    logic out_busy;   // output register still holds an untaken word
  } ctrl_status_t;

  // Clamp a raw size to 1..max_n
  function automatic int eff_size(logic [SIZE_W-1:0] gs, int max_n);
    int n;
    n = int'(gs);
    if (n == 0) n = 1;
    if (n > max_n) n = max_n;
    return n;
  endfunction

endpackage

// ----- design/tpgm_ctrl.sv -----
// Controller state machine: load, seed, three-phase DP step, result hand-off.
module tpgm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tpgm_pkg::ctrl_status_t status,
  output tpgm_pkg::ctrl_cmd_t    cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_INIT0 = 3'd1;
  localparam logic [2:0] S_INIT1 = 3'd2;
  localparam logic [2:0] S_RD0   = 3'd3;
  localparam logic [2:0] S_RD1   = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_LOAD);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && status.grid_last) state_next = S_INIT0;
      end
      S_INIT0: begin
        cmd.init_rd = 1'b1;
        state_next  = S_INIT1;
      end
      S_INIT1: begin
        cmd.init_wr = 1'b1;
        state_next  = status.n_one ? S_FIN : S_RD0;
      end
      S_RD0: begin
        cmd.rd0    = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd1    = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = status.loop_end ? S_FIN : S_RD0;
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
    // A size write drops any grid in progress
    if (clear) begin
      cmd        = '0;
      state_next = S_LOAD;
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

endmodule

// ----- design/tpgm_dp.sv -----
// Datapath: grid store, two-layer DP store, loop indices and output register.
module tpgm_dp #(
  parameter int MAX_N = tpgm_pkg::MAX_N_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic [tpgm_pkg::SIZE_W-1:0]        size_value,
  input  logic [tpgm_pkg::VALUE_W-1:0]       coin_value,
  input  tpgm_pkg::ctrl_cmd_t                cmd,
  output tpgm_pkg::ctrl_status_t             status,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [tpgm_pkg::SUM_W-1:0]         max_total
);

  localparam int D   = MAX_N * MAX_N;
  localparam int AW  = $clog2(D);
  localparam int DAW = $clog2(2 * D);
  localparam int RW  = $clog2(MAX_N);
  localparam int NW  = $clog2(MAX_N + 1);
  localparam int KW  = $clog2(2 * MAX_N - 1);
  localparam int VW  = tpgm_pkg::VALUE_W;
  localparam int SW  = tpgm_pkg::SUM_W;

  logic [NW-1:0] n_q;
  logic [RW-1:0] row, col;
  logic [KW-1:0] k;
  logic [RW-1:0] r1, r2;
  logic          cur;
  logic [SW-1:0] last;

  logic [VW-1:0] grid_mem [D];
  logic [SW-1:0] dp_mem   [2*D];
  logic [VW-1:0] ga_q, gb_q;
  logic [SW-1:0] da_q, db_q;
  logic [SW-1:0] m1_q;
  logic [VW:0]   gain_q;

  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [RW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_N) + AW'(c));
  endfunction

  function automatic logic [DAW-1:0] dp_addr(logic b, logic [RW-1:0] p, logic [RW-1:0] q);
    return DAW'((b ? DAW'(D) : DAW'(0)) + DAW'(p) * DAW'(MAX_N) + DAW'(q));
  endfunction

  // Diagonal bounds for the current and the next step
  logic [KW-1:0] nk, nm1, lo, hi, k1, lo1;
  logic [RW-1:0] n_m1;
  always_comb begin
    nk   = KW'(n_q);
    nm1  = nk - KW'(1);
    n_m1 = RW'(n_q - NW'(1));
    lo   = (k >= nk) ? k - nm1 : '0;
    hi   = (k < nk) ? k : nm1;
    k1   = k + KW'(1);
    lo1  = (k1 >= nk) ? k1 - nm1 : '0;
  end

  // Predecessor validity: same row needs r < k, row above needs r > 0
  logic s1, s2, u1, u2;
  logic [RW-1:0] r1m, r2m;
  always_comb begin
    s1  = KW'(r1) < k;
    s2  = KW'(r2) < k;
    u1  = (r1 != '0);
    u2  = (r2 != '0);
    r1m = u1 ? r1 - RW'(1) : '0;
    r2m = u2 ? r2 - RW'(1) : '0;
  end

  assign status.grid_last = (row == n_m1) && (col == n_m1);
  assign status.n_one     = (n_q == NW'(1));
  assign status.loop_end  = (k == KW'(2) * nk - KW'(2)) && (KW'(r1) == hi) && (KW'(r2) == hi);
  assign status.out_busy  = out_valid && !out_ready;

  // Hold size and load position
  always_ff @(posedge clk) begin
    if (rst) begin
      n_q <= NW'(tpgm_pkg::eff_size(tpgm_pkg::SIZE_RESET, MAX_N));
      row <= '0;
      col <= '0;
    end else if (clear) begin
      n_q <= NW'(tpgm_pkg::eff_size(size_value, MAX_N));
      row <= '0;
      col <= '0;
    end else if (cmd.load) begin
      if (col == n_m1) begin
        col <= '0;
        row <= (row == n_m1) ? '0 : row + RW'(1);
      end else begin
        col <= col + RW'(1);
      end
    end
  end

  // Write cell words into the grid store
  always_ff @(posedge clk) begin
    if (cmd.load) grid_mem[cell_addr(row, col)] <= coin_value;
  end

  // Read the two gain cells, or the corner during seeding
  logic [AW-1:0] gaddr_a, gaddr_b;
  always_comb begin
    gaddr_a = cmd.init_rd ? '0 : cell_addr(r1, RW'(k - KW'(r1)));
    gaddr_b = cell_addr(r2, RW'(k - KW'(r2)));
  end
  always_ff @(posedge clk) begin
    if (cmd.rd0 || cmd.init_rd) begin
      ga_q <= grid_mem[gaddr_a];
      gb_q <= grid_mem[gaddr_b];
    end
  end

  // Read two predecessors from the previous layer each cycle
  logic [DAW-1:0] daddr_a, daddr_b;
  always_comb begin
    daddr_a = cmd.rd1 ? dp_addr(!cur, r1m, r2) : dp_addr(!cur, r1, r2);
    daddr_b = cmd.rd1 ? dp_addr(!cur, r1m, r2m) : dp_addr(!cur, r1, r2m);
  end
  always_ff @(posedge clk) begin
    da_q <= dp_mem[daddr_a];
    db_q <= dp_mem[daddr_b];
  end

  // Combine the first pair and the gain
  logic [SW-1:0] pa, pb;
  always_comb begin
    pa = (s1 && s2) ? da_q : '0;
    pb = (s1 && u2) ? db_q : '0;
  end
  always_ff @(posedge clk) begin
    if (cmd.rd1) begin
      m1_q   <= (pa > pb) ? pa : pb;
      gain_q <= {1'b0, ga_q} + ((r1 != r2) ? {1'b0, gb_q} : '0);
    end
  end

  // Finish the max, add and saturate
  logic [SW-1:0] pc, pd, mx, res;
  logic [SW:0]   sum;
  always_comb begin
    pc  = (u1 && s2) ? da_q : '0;
    pd  = (u1 && u2) ? db_q : '0;
    mx  = (pc > pd) ? pc : pd;
    mx  = (m1_q > mx) ? m1_q : mx;
    sum = {1'b0, mx} + (SW+1)'(gain_q);
    res = sum[SW] ? tpgm_pkg::SUM_LIMIT : sum[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr)           dp_mem[dp_addr(cur, r1, r2)] <= res;
    else if (cmd.init_wr) dp_mem[dp_addr(1'b0, '0, '0)] <= SW'(ga_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr)           last <= res;
    else if (cmd.init_wr) last <= SW'(ga_q);
  end

  // Advance the row pair, then the diagonal
  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= '0;
      r1  <= '0;
      r2  <= '0;
      cur <= 1'b0;
    end else if (cmd.init_wr) begin
      k   <= KW'(1);
      r1  <= '0;
      r2  <= '0;
      cur <= 1'b1;
    end else if (cmd.wr) begin
      if (KW'(r2) != hi) begin
        r2 <= r2 + RW'(1);
      end else if (KW'(r1) != hi) begin
        r1 <= r1 + RW'(1);
        r2 <= RW'(lo);
      end else begin
        k   <= k1;
        r1  <= RW'(lo1);
        r2  <= RW'(lo1);
        cur <= !cur;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)              out_valid <= 1'b0;
    else if (cmd.publish) out_valid <= 1'b1;
    else if (out_ready)   out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.publish) max_total <= last;
  end

endmodule

// ----- design/two_path_grid_max_collect_unit.sv -----
// Top level of the two-path grid collector.
// Use: write the grid side (1..MAX_N; 0 reads as 1, larger values clamp)
// through grid_size_we/grid_size while idle; a write also restarts the grid.
// Then send n*n coin words on in_valid/in_ready/coin_value, row-major.
// Cell words are taken while in_valid is high. After the last one, the
// block runs the two-path DP over the anti-diagonals: it reads, then writes
// the corner cell to seed, then steps through each (row, row) pair on every
// diagonal in states RD0, RD1 and WR: four predecessor reads, taken two per
// cycle from the two-port DP store, fill RD0 and RD1; WR writes the entry.
// in_ready is low during that pass. The result word appears on
// out_valid/out_ready/max_total and is held until taken; loading of the next
// grid goes on meanwhile, and a finished pass waits while the receiver
// stalls. Reset clears the control state, side = min(16, MAX_N), and leaves
// the grid and DP stores unset; they are always written before being read.
module two_path_grid_max_collect_unit #(
  parameter int MAX_N = tpgm_pkg::MAX_N_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         grid_size_we,
  input  logic [tpgm_pkg::SIZE_W-1:0]  grid_size,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tpgm_pkg::VALUE_W-1:0] coin_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tpgm_pkg::SUM_W-1:0]   max_total
);

  tpgm_pkg::ctrl_cmd_t    cmd;
  tpgm_pkg::ctrl_status_t status;

  tpgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .clear    (grid_size_we),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tpgm_dp #(.MAX_N(MAX_N)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .clear      (grid_size_we),
    .size_value (grid_size),
    .coin_value (coin_value),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .max_total  (max_total)
  );

endmodule

// ----- design/tpgm_checker.sv -----
// Port-level checks for the two-path grid collector, bound to the top level.
module tpgm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         grid_size_we,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tpgm_pkg::SUM_W-1:0]   max_total
);

  // After reset: no result pending, ready for cells
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("reset did not leave the block idle");

  // A size write returns the block to loading
  a_cfg: assert property (@(posedge clk) disable iff (rst) grid_size_we |=> in_ready)
    else $error("size write did not restart loading");

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(max_total))
    else $error("result word changed while stalled");

endmodule

bind two_path_grid_max_collect_unit tpgm_checker u_tpgm_checker (.*);
